[hdl/lfdc_pkg.sv]
// Shared types and constants of the line-follow drive controller.
package lfdc_pkg;

  // Field widths
  localparam int GAIN_W  = 20;
  localparam int ILIM_W  = 12;
  localparam int SPEED_W = 14;
  localparam int ACCEL_W = 13;
  localparam int PWM_W   = 15;
  localparam int DRIVE_W = 16;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 20;

  // Datapath widths
  localparam int ERR_W   = 7;   // steering error, tenths, -32..32
  localparam int DER_W   = 8;   // error difference, -64..64
  localparam int SUM_W   = 16;  // clamped error sum
  localparam int PE_W    = 28;
  localparam int IS_W    = 37;
  localparam int DD_W    = 29;
  localparam int S_W     = 38;  // PID sum, 2560 counts per output unit
  localparam int M_W     = 44;  // 23 * PID sum
  localparam int UL_W    = 21;
  localparam int UB_W    = 22;
  localparam int PRODL_W = 43;
  localparam int PRODB_W = 45;
  localparam int QL_W    = 21;
  localparam int QB_W    = 19;
  localparam int ACC_W   = 22;

  // Divide by 5: u in [0, 2^21), floor(u * RECIP5 / 2^24)
  localparam logic [21:0] RECIP5  = 22'd3355444;
  localparam int          SHIFT5  = 24;
  // Divide by 25: u in [0, 2^22), floor(u * RECIP25 / 2^27)
  localparam logic [22:0] RECIP25 = 23'd5368710;
  localparam int          SHIFT25 = 27;

  // Pre-division clamps (beyond them every output saturates anyway)
  localparam longint CLAMP_L  = 524288;   // 2^19
  localparam longint OFFS_L   = 1310720;  // 5 * 2^18
  localparam longint QOFFS_L  = 262144;   // 2^18
  localparam longint CLAMP_B  = 1048576;  // 2^20
  localparam longint OFFS_B   = 1638400;  // 25 * 2^16
  localparam longint QOFFS_B  = 65536;    // 2^16

  // Steering weights in tenths: far left, near left, near right, far right
  localparam logic signed [ERR_W-1:0] SENSOR_WEIGHT [4] = '{
    7'sd20, 7'sd12, -7'sd12, -7'sd20
  };

  localparam int LINE_POLARITY_DEF = 0;

  // Register reset values
  localparam logic [GAIN_W-1:0]         GAIN_P_RST  = 20'd128000;
  localparam logic [GAIN_W-1:0]         GAIN_I_RST  = 20'd0;
  localparam logic [GAIN_W-1:0]         GAIN_D_RST  = 20'd0;
  localparam logic [ILIM_W-1:0]         ILIM_RST    = 12'd1000;
  localparam logic signed [SPEED_W-1:0] CRUISE_RST  = 14'sd800;
  localparam logic signed [SPEED_W-1:0] BACKUP_RST  = -14'sd600;
  localparam logic [ACCEL_W-1:0]        ACCEL_RST   = 13'd100;
  localparam logic [PWM_W-1:0]          PWM_RST     = 15'd6000;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_TURNING   = 2'd1,
    MODE_REVERSING = 2'd2
  } drive_mode_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_ILIM       = 3'd3,
    REG_CRUISE     = 3'd4,
    REG_BACKUP     = 3'd5,
    REG_ACCEL_STEP = 3'd6,
    REG_PWM_LIMIT  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                      v;
    drive_mode_t               mode;
    logic signed [SPEED_W-1:0] speed;
  } stage_info_t;

endpackage

[hdl/line_follow_drive_controller.sv]
// Line-follow drive controller: mode select, speed ramp, steering PID, mixer.
//
// Each input transaction is one control tick: four raw line-sensor bits. The
// block picks a mode (all sensors on the line: reversing at backup_speed; some:
// turning with target 0; none: normal at cruise_speed), ramps the speed toward
// the target by at most the acceleration step, runs a PID on the weighted
// sensor error and mixes left/right/back motor commands, each truncated toward
// zero and saturated to +/- pwm_limit. Throughput is one transaction per clock
// unless the output stalls; results pass the input register, seven pipeline
// stages and the output register. The pipeline moves as a whole: it advances
// whenever the output register is empty or being taken, so an output stall
// holds every stage and in_ready. The speed ramp and the PID state close their
// loop in the first stage, so back-to-back ticks see each other's state. The
// user writes the configuration registers (cfg_we/cfg_addr/cfg_wdata) only while
// the block is idle, which the block does not enforce; reset restores their documented defaults.
module line_follow_drive_controller #(
  parameter int LINE_POLARITY = lfdc_pkg::LINE_POLARITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [lfdc_pkg::CFG_A_W-1:0]          cfg_addr,
  input  logic [lfdc_pkg::CFG_D_W-1:0]          cfg_wdata,
  // sensor transactions
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_sensor_far_left,
  input  logic                                  in_sensor_near_left,
  input  logic                                  in_sensor_near_right,
  input  logic                                  in_sensor_far_right,
  // drive transactions
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lfdc_pkg::DRIVE_W-1:0]   out_left_drive,
  output logic signed [lfdc_pkg::DRIVE_W-1:0]   out_right_drive,
  output logic signed [lfdc_pkg::DRIVE_W-1:0]   out_back_drive,
  output lfdc_pkg::drive_mode_t                 out_drive_mode,
  output logic signed [lfdc_pkg::SPEED_W-1:0]   out_ramped_speed
);
  import lfdc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]         gain_p_r, gain_i_r, gain_d_r;
  logic [ILIM_W-1:0]         ilim_r;
  logic signed [SPEED_W-1:0] cruise_r, backup_r;
  logic [ACCEL_W-1:0]        accel_r;
  logic [PWM_W-1:0]          pwm_r;

  // ---------------------------------------------------------------------------
  // Loop state (speed ramp and PID memory)
  // ---------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] last_speed_r;
  logic signed [SUM_W-1:0]   error_sum_r;
  logic signed [ERR_W-1:0]   last_error_r;

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  logic                      s0_v_r;
  logic [3:0]                s0_sens_r;        // {far_right, near_right, near_left, far_left}
  stage_info_t               info_r [1:7];     // valid, mode and speed riding along

  logic signed [ERR_W-1:0]   s1_err_r;
  logic signed [SUM_W-1:0]   s1_sum_r;
  logic signed [DER_W-1:0]   s1_deriv_r;

  logic signed [PE_W-1:0]    s2_pe_r;
  logic signed [IS_W-1:0]    s2_is_r;
  logic signed [DD_W-1:0]    s2_dd_r;

  logic signed [S_W-1:0]     s3_s_r;

  logic signed [S_W-1:0]     s4_s_r;
  logic signed [M_W-1:0]     s4_m_r;

  logic [UL_W-1:0]           s5_ul_r;
  logic [UB_W-1:0]           s5_ub_r;
  logic                      s5_lowl_r, s5_lowb_r;

  logic [PRODL_W-1:0]        s6_prodl_r;
  logic [PRODB_W-1:0]        s6_prodb_r;
  logic [UL_W-1:0]           s6_ul_r;
  logic [UB_W-1:0]           s6_ub_r;
  logic                      s6_lowl_r, s6_lowb_r;

  logic signed [QL_W-1:0]    s7_ql_r;
  logic signed [QB_W-1:0]    s7_qb_r;
  logic                      s7_nzl_r, s7_nzb_r;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] left_r, right_r, back_r;
  drive_mode_t               mode_r;
  logic signed [SPEED_W-1:0] speed_r;

  // Whole pipeline advances when the output register can take a new result
  logic en;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: mode, speed ramp, PID error terms (closes the state loop)
  // ---------------------------------------------------------------------------
  function automatic logic signed [ERR_W-1:0] steer_error(input logic [3:0] raw);
    logic signed [ERR_W-1:0] e;
    e = '0;
    for (int k = 0; k < 4; k++) begin
      // sensor value is 0 when raw is 1, otherwise -1 (polarity 0) or +1
      if (!raw[k]) begin
        if (LINE_POLARITY == 0) e = e - SENSOR_WEIGHT[k];
        else                    e = e + SENSOR_WEIGHT[k];
      end
    end
    return e;
  endfunction

  logic [3:0]                on_line;
  stage_info_t               info1_nxt;
  logic signed [SPEED_W-1:0] target;
  logic signed [SPEED_W:0]   diff, acc_lim;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [SUM_W:0]     sum_raw, ilim_t;
  logic [SUM_W:0]            ilim_x10;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [DER_W-1:0]   deriv_nxt;

  always_comb begin
    on_line = (LINE_POLARITY == 0) ? s0_sens_r : ~s0_sens_r;

    info1_nxt.v = s0_v_r;
    if (&on_line) begin
      info1_nxt.mode = MODE_REVERSING;
      target         = backup_r;
    end else if (|on_line) begin
      info1_nxt.mode = MODE_TURNING;
      target         = '0;
    end else begin
      info1_nxt.mode = MODE_NORMAL;
      target         = cruise_r;
    end

    // slew limit toward target
    acc_lim = signed'({2'b00, accel_r});
    diff    = (SPEED_W+1)'(target) - (SPEED_W+1)'(last_speed_r);
    if (diff > acc_lim)       diff = acc_lim;
    else if (diff < -acc_lim) diff = -acc_lim;
    info1_nxt.speed = SPEED_W'((SPEED_W+1)'(last_speed_r) + diff);

    // integral with clamp at min(10 * integral_limit, 32767)
    err_nxt  = steer_error(s0_sens_r);
    ilim_x10 = (SUM_W+1)'(ilim_r) * (SUM_W+1)'(10);
    if (ilim_x10 > (SUM_W+1)'(32767)) ilim_t = (SUM_W+1)'(32767);
    else                              ilim_t = signed'(ilim_x10);
    sum_raw = (SUM_W+1)'(error_sum_r) + (SUM_W+1)'(err_nxt);
    if (sum_raw > ilim_t)       sum_raw = ilim_t;
    else if (sum_raw < -ilim_t) sum_raw = -ilim_t;
    sum_nxt   = SUM_W'(sum_raw);
    deriv_nxt = DER_W'(err_nxt) - DER_W'(last_error_r);
  end

  // ---------------------------------------------------------------------------
  // Stages 2..5: PID products, sum, 23x for the back wheel, pre-division clamp
  // ---------------------------------------------------------------------------
  logic signed [PE_W-1:0] pe_nxt;
  logic signed [IS_W-1:0] is_nxt;
  logic signed [DD_W-1:0] dd_nxt;
  logic signed [S_W-1:0]  s_nxt;
  logic signed [M_W-1:0]  s_wide, m_nxt;
  logic signed [S_W-1:0]  xs;
  logic signed [M_W-1:0]  ys;
  logic [UL_W-1:0]        ul_nxt;
  logic [UB_W-1:0]        ub_nxt;

  always_comb begin
    pe_nxt = PE_W'(signed'({1'b0, gain_p_r})) * PE_W'(s1_err_r);
    is_nxt = IS_W'(signed'({1'b0, gain_i_r})) * IS_W'(s1_sum_r);
    dd_nxt = DD_W'(signed'({1'b0, gain_d_r})) * DD_W'(s1_deriv_r);

    s_nxt = S_W'(s2_pe_r) + S_W'(s2_is_r) + S_W'(s2_dd_r);

    // 23 * S by shift and add
    s_wide = M_W'(s3_s_r);
    m_nxt  = (s_wide <<< 4) + (s_wide <<< 2) + (s_wide <<< 1) + s_wide;

    // floor(S / 512), clamped, then offset to a positive multiple-of-5 base
    xs = s4_s_r >>> 9;
    if (xs > S_W'(CLAMP_L))       xs = S_W'(CLAMP_L);
    else if (xs < -S_W'(CLAMP_L)) xs = -S_W'(CLAMP_L);
    ul_nxt = UL_W'(xs + S_W'(OFFS_L));

    // floor(23S / 2048), clamped, offset to a positive multiple-of-25 base
    ys = s4_m_r >>> 11;
    if (ys > M_W'(CLAMP_B))       ys = M_W'(CLAMP_B);
    else if (ys < -M_W'(CLAMP_B)) ys = -M_W'(CLAMP_B);
    ub_nxt = UB_W'(ys + M_W'(OFFS_B));
  end

  // ---------------------------------------------------------------------------
  // Stages 6..7: reciprocal division by 5 and by 25, remainder flags
  // ---------------------------------------------------------------------------
  logic [PRODL_W-1:0]     prodl_nxt;
  logic [PRODB_W-1:0]     prodb_nxt;
  logic [UL_W-3:0]        qul;   // floor(u / 5), 19 bits
  logic [UB_W-5:0]        qub;   // floor(u / 25), 18 bits
  logic signed [QL_W-1:0] ql_nxt;
  logic signed [QB_W-1:0] qb_nxt;
  logic                   nzl_nxt, nzb_nxt;

  always_comb begin
    prodl_nxt = PRODL_W'(s5_ul_r) * PRODL_W'(RECIP5);
    prodb_nxt = PRODB_W'(s5_ub_r) * PRODB_W'(RECIP25);

    qul    = s6_prodl_r[PRODL_W-1:SHIFT5];
    qub    = s6_prodb_r[PRODB_W-1:SHIFT25];
    ql_nxt = signed'({2'b00, qul}) - QL_W'(QOFFS_L);
    qb_nxt = signed'({1'b0, qub}) - QB_W'(QOFFS_B);
    // nonzero remainder of the full division
    nzl_nxt = s6_lowl_r || ((UL_W+1)'(s6_ul_r) != (UL_W+1)'(qul) * (UL_W+1)'(5));
    nzb_nxt = s6_lowb_r || (s6_ub_r != UB_W'(qub) * UB_W'(25));
  end

  // ---------------------------------------------------------------------------
  // Stage 8: mixer, truncation toward zero, saturation
  // ---------------------------------------------------------------------------
  function automatic logic signed [DRIVE_W-1:0] sat(input logic signed [ACC_W-1:0] v,
                                                     input logic [PWM_W-1:0]        lim);
    logic signed [ACC_W-1:0] l;
    l = signed'(ACC_W'(lim));
    if (v > l)       return DRIVE_W'(l);
    else if (v < -l) return DRIVE_W'(-l);
    else             return DRIVE_W'(v);
  endfunction

  logic signed [ACC_W-1:0] spd_w, la, ra, ba;
  logic signed [DRIVE_W-1:0] left_nxt, right_nxt, back_nxt;

  always_comb begin
    spd_w = ACC_W'(info_r[7].speed);
    // floor division plus one where the quotient is negative and inexact
    la = spd_w + ACC_W'(s7_ql_r);
    if (s7_nzl_r && la < 0) la = la + ACC_W'(1);
    ra = -spd_w + ACC_W'(s7_ql_r);
    if (s7_nzl_r && ra < 0) ra = ra + ACC_W'(1);
    ba = ACC_W'(s7_qb_r);
    if (s7_nzb_r && ba < 0) ba = ba + ACC_W'(1);

    if (info_r[7].mode == MODE_REVERSING) begin
      left_nxt  = sat(spd_w, pwm_r);
      right_nxt = sat(spd_w, pwm_r);
      back_nxt  = sat(spd_w, pwm_r);
    end else begin
      left_nxt  = sat(la, pwm_r);
      right_nxt = sat(ra, pwm_r);
      back_nxt  = sat(ba, pwm_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Control, configuration, loop state and per-stage info
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= GAIN_P_RST;
      gain_i_r     <= GAIN_I_RST;
      gain_d_r     <= GAIN_D_RST;
      ilim_r       <= ILIM_RST;
      cruise_r     <= CRUISE_RST;
      backup_r     <= BACKUP_RST;
      accel_r      <= ACCEL_RST;
      pwm_r        <= PWM_RST;
      last_speed_r <= '0;
      error_sum_r  <= '0;
      last_error_r <= '0;
      s0_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 1; k <= 7; k++) info_r[k].v <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_GAIN_P:     gain_p_r <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I:     gain_i_r <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:     gain_d_r <= cfg_wdata[GAIN_W-1:0];
          REG_ILIM:       ilim_r   <= cfg_wdata[ILIM_W-1:0];
          REG_CRUISE:     cruise_r <= signed'(cfg_wdata[SPEED_W-1:0]);
          REG_BACKUP:     backup_r <= signed'(cfg_wdata[SPEED_W-1:0]);
          REG_ACCEL_STEP: accel_r  <= cfg_wdata[ACCEL_W-1:0];
          REG_PWM_LIMIT:  pwm_r    <= cfg_wdata[PWM_W-1:0];
          default: ;
        endcase
      end
      if (en) begin
        s0_v_r    <= in_valid;
        info_r[1] <= info1_nxt;
        for (int k = 2; k <= 7; k++) info_r[k] <= info_r[k-1];
        out_valid_r <= info_r[7].v;
        if (s0_v_r) begin
          last_speed_r <= info1_nxt.speed;
          error_sum_r  <= sum_nxt;
          last_error_r <= err_nxt;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s0_sens_r <= {in_sensor_far_right, in_sensor_near_right,
                    in_sensor_near_left, in_sensor_far_left};

      s1_err_r   <= err_nxt;
      s1_sum_r   <= sum_nxt;
      s1_deriv_r <= deriv_nxt;

      s2_pe_r <= pe_nxt;
      s2_is_r <= is_nxt;
      s2_dd_r <= dd_nxt;

      s3_s_r <= s_nxt;

      s4_s_r <= s3_s_r;
      s4_m_r <= m_nxt;

      s5_ul_r   <= ul_nxt;
      s5_ub_r   <= ub_nxt;
      s5_lowl_r <= |s4_s_r[8:0];
      s5_lowb_r <= |s4_m_r[10:0];

      s6_prodl_r <= prodl_nxt;
      s6_prodb_r <= prodb_nxt;
      s6_ul_r    <= s5_ul_r;
      s6_ub_r    <= s5_ub_r;
      s6_lowl_r  <= s5_lowl_r;
      s6_lowb_r  <= s5_lowb_r;

      s7_ql_r  <= ql_nxt;
      s7_qb_r  <= qb_nxt;
      s7_nzl_r <= nzl_nxt;
      s7_nzb_r <= nzb_nxt;

      left_r  <= left_nxt;
      right_r <= right_nxt;
      back_r  <= back_nxt;
      mode_r  <= info_r[7].mode;
      speed_r <= info_r[7].speed;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_drive   = left_r;
  assign out_right_drive  = right_r;
  assign out_back_drive   = back_r;
  assign out_drive_mode   = mode_r;
  assign out_ramped_speed = speed_r;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the line-follow drive controller.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lfdc_pkg::*;

  localparam int POLARITY   = LINE_POLARITY_DEF;
  localparam int PHASES     = 6;
  localparam int PHASE_RUN  = 65;         // minimum sensor transactions per register setting
  localparam int LONG_HOLD  = 60;         // one long output stall, in cycles
  localparam int HOLD_AT    = 120;        // ... started after this many drive results
  localparam int DRAIN      = 20;         // pipeline is 9 deep plus slack
  localparam int TIME_LIMIT = 5_000_000;  // ns, far above the slowest legal run
  localparam int N_ROWS     = 22;

  // One drive result, as the block presents it
  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic signed [DRIVE_W-1:0] back;
    drive_mode_t               mode;
    logic signed [SPEED_W-1:0] speed;
  } drive_cmd_t;

  // Directed row: sensor bits {far_left, near_left, near_right, far_right}
  typedef struct packed {
    logic [3:0] sensors;
    logic       typed;
    drive_cmd_t want;
  } tick_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr = '0;
  logic [CFG_D_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_sensor_far_left = 1'b0;
  logic                in_sensor_near_left = 1'b0;
  logic                in_sensor_near_right = 1'b0;
  logic                in_sensor_far_right = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [DRIVE_W-1:0] out_left_drive;
  logic signed [DRIVE_W-1:0] out_right_drive;
  logic signed [DRIVE_W-1:0] out_back_drive;
  drive_mode_t               out_drive_mode;
  logic signed [SPEED_W-1:0] out_ramped_speed;

  // Register mirror, reset values
  logic [GAIN_W-1:0]         gain_p = 20'd128000;
  logic [GAIN_W-1:0]         gain_i = '0;
  logic [GAIN_W-1:0]         gain_d = '0;
  logic [ILIM_W-1:0]         ilim = 12'd1000;
  logic signed [SPEED_W-1:0] cruise = 14'sd800;
  logic signed [SPEED_W-1:0] backup = -14'sd600;
  logic [ACCEL_W-1:0]        accel = 13'd100;
  logic [PWM_W-1:0]          pwm_lim = 15'd6000;

  // Controller state mirror, all zero after reset
  logic signed [SPEED_W-1:0] ramp_speed = '0;
  logic signed [SUM_W-1:0]   err_acc = '0;
  logic signed [ERR_W-1:0]   prev_err = '0;

  drive_cmd_t drive_q [$];   // drive results still owed by the block
  int         drives_seen = 0;
  int         fails = 0;
  bit         steady = 1'b0; // no random idling on either side while set

  // Directed ticks after reset. Only the first four have hand-worked results:
  // a cruise ramp step, a reverse step, and hard left / hard right turns at
  // the default P gain of 500.
  tick_row_t plan [N_ROWS] = '{
    '{4'b0000, 1'b1, '{16'sd100, -16'sd100, 16'sd0, MODE_NORMAL, 14'sd100}},
    '{4'b1111, 1'b1, '{16'sd0, 16'sd0, 16'sd0, MODE_REVERSING, 14'sd0}},
    '{4'b1000, 1'b1, '{16'sd1000, 16'sd1000, 16'sd1150, MODE_TURNING, 14'sd0}},
    '{4'b0001, 1'b1, '{-16'sd1000, -16'sd1000, -16'sd1150, MODE_TURNING, 14'sd0}},
    '{4'b0100, 1'b0, '0}, '{4'b0010, 1'b0, '0}, '{4'b1100, 1'b0, '0},
    '{4'b0011, 1'b0, '0}, '{4'b0110, 1'b0, '0}, '{4'b1001, 1'b0, '0},
    '{4'b1110, 1'b0, '0}, '{4'b0111, 1'b0, '0}, '{4'b1010, 1'b0, '0},
    '{4'b0101, 1'b0, '0}, '{4'b1011, 1'b0, '0}, '{4'b1101, 1'b0, '0},
    '{4'b0000, 1'b0, '0}, '{4'b0000, 1'b0, '0}, '{4'b0000, 1'b0, '0},
    '{4'b1111, 1'b0, '0}, '{4'b1111, 1'b0, '0}, '{4'b0000, 1'b0, '0}
  };

  line_follow_drive_controller #(
    .LINE_POLARITY(POLARITY)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sensor_far_left   (in_sensor_far_left),
    .in_sensor_near_left  (in_sensor_near_left),
    .in_sensor_near_right (in_sensor_near_right),
    .in_sensor_far_right  (in_sensor_far_right),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_left_drive       (out_left_drive),
    .out_right_drive      (out_right_drive),
    .out_back_drive       (out_back_drive),
    .out_drive_mode       (out_drive_mode),
    .out_ramped_speed     (out_ramped_speed)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // One control tick: mode pick, speed ramp, steering PID, mixer, saturation.
  // Advances the state mirror; all math is done wide and signed.
  function automatic drive_cmd_t drive_tick(logic [3:0] sensors);
    int         weight [4] = '{20, 12, -12, -20};
    int         on_cnt;
    int         raw;
    longint     tgt, spd, err, lim, total, dv, s, l, r, b, pl, ac, gp, gi, gd;
    drive_mode_t mode;
    drive_cmd_t c;
    on_cnt = 0;
    err = 0;
    for (int i = 0; i < 4; i++) begin
      raw = int'(sensors[3-i]);
      if (POLARITY != 0) begin
        on_cnt += (raw == 0);
        err += weight[i] * (1 - raw);
      end else begin
        on_cnt += raw;
        err += weight[i] * (raw - 1);
      end
    end
    if (on_cnt == 4) begin
      mode = MODE_REVERSING;
      tgt = longint'(backup);
    end else if (on_cnt > 0) begin
      mode = MODE_TURNING;
      tgt = 0;
    end else begin
      mode = MODE_NORMAL;
      tgt = longint'(cruise);
    end
    // slew limit toward the target; never overshoots it
    ac = longint'(accel);
    spd = tgt - longint'(ramp_speed);
    if (spd > ac) spd = ac;
    else if (spd < -ac) spd = -ac;
    spd += longint'(ramp_speed);
    ramp_speed = SPEED_W'(spd);
    // integral clamp in tenths
    lim = longint'(ilim) * 10;
    if (lim > 32767) lim = 32767;
    total = longint'(err_acc) + err;
    if (total > lim) total = lim;
    if (total < -lim) total = -lim;
    err_acc = SUM_W'(total);
    dv = err - longint'(prev_err);
    prev_err = ERR_W'(err);
    gp = longint'(gain_p);
    gi = longint'(gain_i);
    gd = longint'(gain_d);
    s = gp * err + gi * total + gd * dv;
    if (mode == MODE_REVERSING) begin
      l = spd;
      r = spd;
      b = spd;
    end else begin
      l = (spd * 2560 + s) / 2560;
      r = (-spd * 2560 + s) / 2560;
      b = (s * 115) / 256000;
    end
    pl = longint'(pwm_lim);
    l = (l > pl) ? pl : ((l < -pl) ? -pl : l);
    r = (r > pl) ? pl : ((r < -pl) ? -pl : r);
    b = (b > pl) ? pl : ((b < -pl) ? -pl : b);
    c.left  = DRIVE_W'(l);
    c.right = DRIVE_W'(r);
    c.back  = DRIVE_W'(b);
    c.mode  = mode;
    c.speed = SPEED_W'(spd);
    return c;
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long gap
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 65) return 0;
    if (r < 95) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  function automatic logic [CFG_D_W-1:0] speed_word(int v);
    logic [SPEED_W-1:0] w;
    w = v[SPEED_W-1:0];
    return {{(CFG_D_W-SPEED_W){w[SPEED_W-1]}}, w};
  endfunction

  task automatic report_miss(input string what);
    fails++;
    if (fails <= 10) $display("%t mismatch: %s", $realtime, what);
  endtask

  // Writes all eight registers on consecutive edges and updates the mirror
  task automatic program_regs(input logic [CFG_D_W-1:0] vals [8]);
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_A_W'(k);
      cfg_wdata <= vals[k];
      @(posedge clk);
      case (cfg_reg_t'(k))
        REG_GAIN_P:     gain_p  = vals[k][GAIN_W-1:0];
        REG_GAIN_I:     gain_i  = vals[k][GAIN_W-1:0];
        REG_GAIN_D:     gain_d  = vals[k][GAIN_W-1:0];
        REG_ILIM:       ilim    = vals[k][ILIM_W-1:0];
        REG_CRUISE:     cruise  = vals[k][SPEED_W-1:0];
        REG_BACKUP:     backup  = vals[k][SPEED_W-1:0];
        REG_ACCEL_STEP: accel   = vals[k][ACCEL_W-1:0];
        REG_PWM_LIMIT:  pwm_lim = vals[k][PWM_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one sensor transaction, holds it until taken, then books the
  // expected drive result (hand-worked value if given, else the prediction).
  task automatic send_tick(input logic [3:0] sensors, input logic typed,
                           input drive_cmd_t want);
    int         gap;
    drive_cmd_t predicted;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_sensor_far_left, in_sensor_near_left,
     in_sensor_near_right, in_sensor_far_right} <= sensors;
    do @(posedge clk); while (!in_ready);
    predicted = drive_tick(sensors);
    drive_q.push_back(typed ? want : predicted);
  endtask

  // Stimulus: reset, directed ticks, then one random run per register setting
  initial begin
    logic [CFG_D_W-1:0] regs [8];
    logic [3:0]         sensors;
    int                 r, reps, sent;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs on the reset register values
    for (int n = 0; n < N_ROWS; n++)
      send_tick(plan[n].sensors, plan[n].typed, plan[n].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only with the pipeline empty
      in_valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clk);
      repeat (DRAIN) @(posedge clk);

      steady = (ph == 0);
      case (ph)
        0: begin  // reset-like speeds with all three PID terms active
          regs[REG_GAIN_P]     = 20'd128000;
          regs[REG_GAIN_I]     = 20'd768;
          regs[REG_GAIN_D]     = 20'd12800;
          regs[REG_ILIM]       = 20'd1000;
          regs[REG_CRUISE]     = speed_word(800);
          regs[REG_BACKUP]     = speed_word(-600);
          regs[REG_ACCEL_STEP] = 20'd100;
          regs[REG_PWM_LIMIT]  = 20'd6000;
        end
        1: begin  // every register at an extreme of its width, backup at its negative end
          regs[REG_GAIN_P]     = 20'hFFFFF;
          regs[REG_GAIN_I]     = 20'hFFFFF;
          regs[REG_GAIN_D]     = 20'hFFFFF;
          regs[REG_ILIM]       = 20'hFFF;
          regs[REG_CRUISE]     = speed_word(8191);
          regs[REG_BACKUP]     = speed_word(-8192);
          regs[REG_ACCEL_STEP] = 20'h1FFF;
          regs[REG_PWM_LIMIT]  = 20'h7FFF;
        end
        2: begin  // zeros: no steering, frozen speed, outputs pinned at zero
          regs[REG_GAIN_P]     = '0;
          regs[REG_GAIN_I]     = '0;
          regs[REG_GAIN_D]     = '0;
          regs[REG_ILIM]       = '0;
          regs[REG_CRUISE]     = speed_word(-8192);
          regs[REG_BACKUP]     = speed_word(8191);
          regs[REG_ACCEL_STEP] = '0;
          regs[REG_PWM_LIMIT]  = '0;
        end
        3: begin  // edges of the documented operating range
          regs[REG_GAIN_P]     = CFG_D_W'($urandom_range(0, 400000));
          regs[REG_GAIN_I]     = CFG_D_W'($urandom_range(0, 5000));
          regs[REG_GAIN_D]     = CFG_D_W'($urandom_range(0, 100000));
          regs[REG_ILIM]       = 20'd3000;
          regs[REG_CRUISE]     = speed_word(6000);
          regs[REG_BACKUP]     = speed_word(-6000);
          regs[REG_ACCEL_STEP] = 20'd6000;
          regs[REG_PWM_LIMIT]  = 20'd32767;
        end
        4: begin  // raw random words, junk above each register's width
          for (int k = 0; k < 8; k++)
            regs[k] = CFG_D_W'($urandom_range(0, (1 << CFG_D_W) - 1));
        end
        default: begin  // tame random: small integral clamp, moderate limits
          regs[REG_GAIN_P]     = CFG_D_W'($urandom_range(0, 200000));
          regs[REG_GAIN_I]     = CFG_D_W'($urandom_range(0, 4000));
          regs[REG_GAIN_D]     = CFG_D_W'($urandom_range(0, 50000));
          regs[REG_ILIM]       = CFG_D_W'($urandom_range(0, 30));
          regs[REG_CRUISE]     = speed_word(int'($urandom_range(0, 12000)) - 6000);
          regs[REG_BACKUP]     = speed_word(int'($urandom_range(0, 12000)) - 6000);
          regs[REG_ACCEL_STEP] = CFG_D_W'($urandom_range(1, 400));
          regs[REG_PWM_LIMIT]  = CFG_D_W'($urandom_range(500, 12000));
        end
      endcase
      program_regs(regs);

      // runs of one pattern wind the integrator into its clamp and let the
      // ramp reach its target; all-on and all-off are favored
      sent = 0;
      while (sent < PHASE_RUN) begin
        r = int'($urandom_range(0, 9));
        sensors = (r == 0) ? 4'b1111 : ((r == 1) ? 4'b0000 : 4'($urandom_range(0, 15)));
        reps = int'($urandom_range(1, 6));
        repeat (reps) begin
          send_tick(sensors, 1'b0, '0);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0 && drive_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Drive side: checks each accepted transaction, then picks the next ready.
  // Values are read right after the edge, i.e. as they stood at the edge.
  initial begin
    int         stall_left;
    bit         held;
    drive_cmd_t want;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        drives_seen++;
        if (drive_q.size() == 0) begin
          report_miss($sformatf("unexpected drive result left %0d right %0d",
                                out_left_drive, out_right_drive));
        end else begin
          want = drive_q.pop_front();
          if (out_left_drive !== want.left || out_right_drive !== want.right ||
              out_back_drive !== want.back || out_drive_mode !== want.mode ||
              out_ramped_speed !== want.speed)
            report_miss($sformatf(
              "#%0d exp L %0d R %0d B %0d mode %0d spd %0d, got L %0d R %0d B %0d mode %0d spd %0d",
              drives_seen, want.left, want.right, want.back, want.mode, want.speed,
              out_left_drive, out_right_drive, out_back_drive, out_drive_mode,
              out_ramped_speed));
        end
      end
      // one long stall so the pipeline backs up into in_ready
      if (stall_left > 0)
        stall_left--;
      else if (!held && drives_seen >= HOLD_AT) begin
        held = 1'b1;
        stall_left = LONG_HOLD;
      end else
        stall_left = idle_gap();
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    #TIME_LIMIT;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
